// ===== hdl/rms_pkg.sv =====
// rms_pkg: shared types and constants of the rate monotonic task scheduler
`timescale 1ns / 1ps
package rms_pkg;

   // field widths
   localparam int ID_W     = 22;
   localparam int PERIOD_W = 16;
   localparam int UTIL_W   = 10;
   localparam int PHASE_W  = 2;
   localparam int PROD_W   = 26;   // compute_ms * 1000 fits in 26 bits

   localparam logic [UTIL_W-1:0] UTIL_BOUND = UTIL_W'(693);
   localparam logic [9:0]        PER_MILLE  = 10'd1000;

   typedef enum logic [1:0] {
      OP_REGISTER   = 2'd0,
      OP_YIELD      = 2'd1,
      OP_DEREGISTER = 2'd2,
      OP_WAKE       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_REFUSED   = 2'd1,
      ST_NO_SLOT   = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   localparam logic [PHASE_W-1:0] PH_SLEEP = 2'd0;
   localparam logic [PHASE_W-1:0] PH_READY = 2'd1;
   localparam logic [PHASE_W-1:0] PH_RUN   = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_PICK,
      S_MUL,
      S_DIV_GO,
      S_DIV_WAIT,
      S_ADMIT,
      S_RID
   } state_type;

   // write controls into the task table
   typedef struct packed {
      logic                we_entry;
      logic                we_phase;
      logic [ID_W-1:0]     id;
      logic [PERIOD_W-1:0] period;
      logic [UTIL_W-1:0]   util;
      logic [PHASE_W-1:0]  phase;
   } tbl_wr_type;

endpackage

// ===== hdl/rate_monotonic_task_scheduler.sv =====
// rate_monotonic_task_scheduler: sequencer, slot scan and admission test
//
// Command port: an operation (register, yield, deregister, wake) is taken at
// a rising edge with start high and busy low. busy stays high while the
// command runs. Its single result appears on the rsp_ ports for one cycle,
// flagged by rsp_valid; the receiver cannot hold it off.
// Every command but a zero period register scans the task table one slot per
// cycle through the table's registered read port.
// Yield and wake: scan, marking the winner running, reading its id, showing
// the result. Deregister, and register into a full table: scan, reading the
// running id, showing the result. Register: scan, multiply, divide, admission
// test, reading the running id, showing the result; the restoring divider adds
// one quotient bit per cycle over 26 bits for the per-mille utilization.
// A zero period register skips the scan and reports no slot.
// A new command can be given in the cycle its result is shown.
// Reset (synchronous) clears the valid bits of all slots, the running task
// and the utilization sum; the table itself needs no clearing pass.
`timescale 1ns / 1ps
module rate_monotonic_task_scheduler #(
   parameter int MAX_TASKS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_operation,
   input  logic [rms_pkg::ID_W-1:0]      req_task_id,
   input  logic [rms_pkg::PERIOD_W-1:0]  req_period_ms,
   input  logic [rms_pkg::PERIOD_W-1:0]  req_compute_ms,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_running_valid,
   output logic [rms_pkg::ID_W-1:0]      rsp_running_id,
   output logic [rms_pkg::UTIL_W-1:0]    rsp_total_utilization
);
   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = IW + 1;
   localparam int SUM_W = rms_pkg::PROD_W + 1;

   rms_pkg::state_type   state_ff, state_in;
   rms_pkg::op_type      op_ff, op_in;
   rms_pkg::status_type  status_ff, status_in;

   logic [rms_pkg::ID_W-1:0]     id_ff, id_in;
   logic [rms_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [rms_pkg::PERIOD_W-1:0] compute_ff, compute_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         pv_ff, pv_in;
   logic [IW-1:0]                idx_ff, idx_in;
   logic                         hit_ff, hit_in;
   logic                         found_ff, found_in;
   logic [IW-1:0]                best_ff, best_in;
   logic [rms_pkg::PERIOD_W-1:0] best_period_ff, best_period_in;
   logic                         have_free_ff, have_free_in;
   logic [IW-1:0]                free_ff, free_in;
   logic [rms_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [MAX_TASKS-1:0]         slot_valid_ff, slot_valid_in;
   logic [IW-1:0]                running_slot_ff, running_slot_in;
   logic                         running_flag_ff, running_flag_in;
   logic [rms_pkg::UTIL_W-1:0]   util_sum_ff, util_sum_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   rms_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic                         rsp_run_ff, rsp_run_in;
   logic [rms_pkg::ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [rms_pkg::UTIL_W-1:0]   rsp_util_ff, rsp_util_in;

   logic [IW-1:0]                rd_addr, wr_addr;
   rms_pkg::tbl_wr_type          wr;
   logic [rms_pkg::ID_W-1:0]     rd_id;
   logic [rms_pkg::PERIOD_W-1:0] rd_period;
   logic [rms_pkg::UTIL_W-1:0]   rd_util;
   logic [rms_pkg::PHASE_W-1:0]  rd_phase;
   logic                         div_start, div_done;
   logic [rms_pkg::PROD_W-1:0]   quotient;
   logic [SUM_W-1:0]             admit_sum;
   logic                         slot_live, slot_match;
   logic [rms_pkg::PHASE_W-1:0]  new_phase;

   rms_table #(.MAX_TASKS(MAX_TASKS), .IW(IW)) u_table (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr        (wr),
      .rd_id     (rd_id),
      .rd_period (rd_period),
      .rd_util   (rd_util),
      .rd_phase  (rd_phase)
   );

   rms_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (period_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign admit_sum = SUM_W'(util_sum_ff) + SUM_W'(quotient);

   // sequencer: next state, scan processing and table writes
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      status_in       = status_ff;
      id_in           = id_ff;
      period_in       = period_ff;
      compute_in      = compute_ff;
      cnt_in          = cnt_ff;
      pv_in           = 1'b0;
      idx_in          = cnt_ff[IW-1:0];
      hit_in          = hit_ff;
      found_in        = found_ff;
      best_in         = best_ff;
      best_period_in  = best_period_ff;
      have_free_in    = have_free_ff;
      free_in         = free_ff;
      prod_in         = prod_ff;
      slot_valid_in   = slot_valid_ff;
      running_slot_in = running_slot_ff;
      running_flag_in = running_flag_ff;
      util_sum_in     = util_sum_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_run_in      = rsp_run_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_util_in     = rsp_util_ff;
      rd_addr         = cnt_ff[IW-1:0];
      wr_addr         = idx_ff;
      wr              = '0;
      div_start       = 1'b0;
      slot_live       = pv_ff && slot_valid_ff[idx_ff];
      slot_match      = slot_live && (rd_id == id_ff);
      new_phase       = slot_match
                        ? ((op_ff == rms_pkg::OP_WAKE) ? rms_pkg::PH_READY : rms_pkg::PH_SLEEP)
                        : rd_phase;

      unique case (state_ff)
         rms_pkg::S_IDLE: begin
            if (start) begin
               op_in        = rms_pkg::op_type'(req_operation);
               id_in        = req_task_id;
               period_in    = req_period_ms;
               compute_in   = req_compute_ms;
               cnt_in       = '0;
               hit_in       = 1'b0;
               found_in     = 1'b0;
               have_free_in = 1'b0;
               status_in    = rms_pkg::ST_DONE;
               if (rms_pkg::op_type'(req_operation) == rms_pkg::OP_REGISTER &&
                   req_period_ms == '0) begin
                  status_in = rms_pkg::ST_NO_SLOT;
                  state_in  = rms_pkg::S_RID;
               end else begin
                  state_in = rms_pkg::S_SCAN;
               end
            end
         end

         rms_pkg::S_SCAN: begin
            // issue next slot read
            if (cnt_ff < CW'(MAX_TASKS)) begin
               pv_in  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            // process slot read in the previous cycle
            unique case (op_ff)
               rms_pkg::OP_REGISTER: begin
                  if (pv_ff && !slot_valid_ff[idx_ff] && !have_free_ff) begin
                     have_free_in = 1'b1;
                     free_in      = idx_ff;
                  end
               end
               rms_pkg::OP_DEREGISTER: begin
                  if (slot_match) begin
                     hit_in                 = 1'b1;
                     slot_valid_in[idx_ff]  = 1'b0;
                     util_sum_in            = util_sum_ff - rd_util;
                     if (running_flag_ff && running_slot_ff == idx_ff) begin
                        running_flag_in = 1'b0;
                        running_slot_in = '0;
                     end
                  end
               end
               rms_pkg::OP_YIELD, rms_pkg::OP_WAKE: begin
                  if (slot_match) begin
                     hit_in = 1'b1;
                  end
                  if (slot_live && (new_phase == rms_pkg::PH_READY ||
                                    new_phase == rms_pkg::PH_RUN)) begin
                     if (!found_ff || rd_period < best_period_ff) begin
                        found_in       = 1'b1;
                        best_in        = idx_ff;
                        best_period_in = rd_period;
                     end
                  end
                  // running task drops back to ready, matched tasks take new phase
                  if (slot_live && (slot_match || new_phase == rms_pkg::PH_RUN)) begin
                     wr.we_phase = 1'b1;
                     wr.phase    = (new_phase == rms_pkg::PH_RUN) ? rms_pkg::PH_READY
                                                                  : new_phase;
                  end
               end
               default: ;
            endcase
            // scan complete
            if (cnt_ff == CW'(MAX_TASKS) && !pv_ff) begin
               unique case (op_ff)
                  rms_pkg::OP_REGISTER: begin
                     if (have_free_ff) begin
                        state_in = rms_pkg::S_MUL;
                     end else begin
                        status_in = rms_pkg::ST_NO_SLOT;
                        state_in  = rms_pkg::S_RID;
                     end
                  end
                  rms_pkg::OP_DEREGISTER: begin
                     status_in = hit_ff ? rms_pkg::ST_DONE : rms_pkg::ST_NOT_FOUND;
                     state_in  = rms_pkg::S_RID;
                  end
                  default: begin
                     status_in = hit_ff ? rms_pkg::ST_DONE : rms_pkg::ST_NOT_FOUND;
                     state_in  = rms_pkg::S_PICK;
                  end
               endcase
            end
         end

         rms_pkg::S_PICK: begin
            wr_addr = best_ff;
            if (found_ff) begin
               wr.we_phase     = 1'b1;
               wr.phase        = rms_pkg::PH_RUN;
               running_slot_in = best_ff;
               running_flag_in = 1'b1;
            end else begin
               running_slot_in = '0;
               running_flag_in = 1'b0;
            end
            state_in = rms_pkg::S_RID;
         end

         rms_pkg::S_MUL: begin
            prod_in  = rms_pkg::PROD_W'(compute_ff) * rms_pkg::PROD_W'(rms_pkg::PER_MILLE);
            state_in = rms_pkg::S_DIV_GO;
         end

         rms_pkg::S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = rms_pkg::S_DIV_WAIT;
         end

         rms_pkg::S_DIV_WAIT: begin
            if (div_done) begin
               state_in = rms_pkg::S_ADMIT;
            end
         end

         rms_pkg::S_ADMIT: begin
            wr_addr = free_ff;
            if (admit_sum > SUM_W'(rms_pkg::UTIL_BOUND)) begin
               status_in = rms_pkg::ST_REFUSED;
            end else begin
               wr.we_entry            = 1'b1;
               wr.we_phase            = 1'b1;
               wr.id                  = id_ff;
               wr.period              = period_ff;
               wr.util                = quotient[rms_pkg::UTIL_W-1:0];
               wr.phase               = rms_pkg::PH_SLEEP;
               slot_valid_in[free_ff] = 1'b1;
               util_sum_in            = util_sum_ff + quotient[rms_pkg::UTIL_W-1:0];
               status_in              = rms_pkg::ST_DONE;
            end
            state_in = rms_pkg::S_RID;
         end

         rms_pkg::S_RID: begin
            // read running id; registered data is valid in the result cycle
            rd_addr = running_slot_ff;
            if (!pv_ff) begin
               pv_in = 1'b1;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_run_in    = running_flag_ff;
               rsp_id_in     = running_flag_ff ? rd_id : '0;
               rsp_util_in   = util_sum_ff;
               state_in      = rms_pkg::S_IDLE;
            end
         end

         default: state_in = rms_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= rms_pkg::S_IDLE;
         pv_ff           <= 1'b0;
         slot_valid_ff   <= '0;
         running_slot_ff <= '0;
         running_flag_ff <= 1'b0;
         util_sum_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pv_ff           <= pv_in;
         slot_valid_ff   <= slot_valid_in;
         running_slot_ff <= running_slot_in;
         running_flag_ff <= running_flag_in;
         util_sum_ff     <= util_sum_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      op_ff          <= op_in;
      status_ff      <= status_in;
      id_ff          <= id_in;
      period_ff      <= period_in;
      compute_ff     <= compute_in;
      cnt_ff         <= cnt_in;
      idx_ff         <= idx_in;
      hit_ff         <= hit_in;
      found_ff       <= found_in;
      best_ff        <= best_in;
      best_period_ff <= best_period_in;
      have_free_ff   <= have_free_in;
      free_ff        <= free_in;
      prod_ff        <= prod_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_run_ff     <= rsp_run_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_util_ff    <= rsp_util_in;
   end

   assign busy                  = (state_ff != rms_pkg::S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_running_valid     = rsp_run_ff;
   assign rsp_running_id        = rsp_id_ff;
   assign rsp_total_utilization = rsp_util_ff;

   // result strobe only once the sequencer has returned to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == rms_pkg::S_IDLE))
      else $error("result shown while sequencer busy");

   // admitted utilization never passes the bound
   a_util_bound: assert property (@(posedge clock) disable iff (reset)
      util_sum_ff <= rms_pkg::UTIL_BOUND)
      else $error("utilization sum above bound");

   // no running task means running slot is zero
   a_run_slot: assert property (@(posedge clock) disable iff (reset)
      !running_flag_ff |-> (running_slot_ff == '0))
      else $error("running slot set without running task");

   // no running task reported means id zero
   a_rsp_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_run_ff) |-> (rsp_id_ff == '0))
      else $error("running id nonzero with no running task");
endmodule

// ===== hdl/rms_divider.sv =====
// rms_divider: restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rms_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rms_pkg::PROD_W-1:0]    dividend,
   input  logic [rms_pkg::PERIOD_W-1:0]  divisor,
   output logic                          done,
   output logic [rms_pkg::PROD_W-1:0]    quotient
);
   localparam int CW = $clog2(rms_pkg::PROD_W + 1);

   logic [rms_pkg::PROD_W-1:0]   quo_ff, quo_in;
   logic [rms_pkg::PERIOD_W:0]   rem_ff, rem_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [rms_pkg::PERIOD_W:0]   trial;

   // one shift and trial subtract per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[rms_pkg::PERIOD_W-1:0], quo_ff[rms_pkg::PROD_W-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in = {quo_ff[rms_pkg::PROD_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[rms_pkg::PROD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(rms_pkg::PROD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== hdl/rms_table.sv =====
// rms_table: task table memory with one registered read port
`timescale 1ns / 1ps
module rms_table #(
   parameter int MAX_TASKS = 16,
   parameter int IW        = 4
) (
   input  logic                          clock,
   input  logic [IW-1:0]                 rd_addr,
   input  logic [IW-1:0]                 wr_addr,
   input  rms_pkg::tbl_wr_type           wr,
   output logic [rms_pkg::ID_W-1:0]      rd_id,
   output logic [rms_pkg::PERIOD_W-1:0]  rd_period,
   output logic [rms_pkg::UTIL_W-1:0]    rd_util,
   output logic [rms_pkg::PHASE_W-1:0]   rd_phase
);
   logic [rms_pkg::ID_W-1:0]     id_mem     [MAX_TASKS];
   logic [rms_pkg::PERIOD_W-1:0] period_mem [MAX_TASKS];
   logic [rms_pkg::UTIL_W-1:0]   util_mem   [MAX_TASKS];
   logic [rms_pkg::PHASE_W-1:0]  phase_mem  [MAX_TASKS];

   // write port
   always_ff @(posedge clock) begin
      if (wr.we_entry) begin
         id_mem[wr_addr]     <= wr.id;
         period_mem[wr_addr] <= wr.period;
         util_mem[wr_addr]   <= wr.util;
      end
      if (wr.we_phase) begin
         phase_mem[wr_addr] <= wr.phase;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_id     <= id_mem[rd_addr];
      rd_period <= period_mem[rd_addr];
      rd_util   <= util_mem[rd_addr];
      rd_phase  <= phase_mem[rd_addr];
   end
endmodule

// ===== tb/sv/tb_rate_monotonic_task_scheduler.sv =====
// tb_rate_monotonic_task_scheduler: self-checking testbench of the task scheduler
`timescale 1ns / 1ps

// scoreboard: task table predictor plus queue of expected responses
class sched_scoreboard;
   localparam int SLOTS = 16;

   typedef struct packed {
      logic [1:0]                 status;
      logic                       run_valid;
      logic [rms_pkg::ID_W-1:0]   run_id;
      logic [rms_pkg::UTIL_W-1:0] util;
   } rsp_type;

   bit                          used [SLOTS];
   logic [rms_pkg::ID_W-1:0]    ids [SLOTS];
   logic [15:0]                 periods [SLOTS];
   logic [9:0]                  utils [SLOTS];
   logic [1:0]                  phases [SLOTS];
   int unsigned                 cur_slot;
   bit                          cur_flag;
   logic [9:0]                  util_sum;
   rsp_type                     pending [$];
   int                          errors;

   function void clear();
      for (int i = 0; i < SLOTS; i++) used[i] = 0;
      cur_slot = 0; cur_flag = 0; util_sum = 0; errors = 0;
      pending.delete();
   endfunction

   function int live_count();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) n += used[i];
      return n;
   endfunction

   // shortest period among ready or running tasks wins, lowest slot on ties
   function void reschedule();
      bit found;
      int best;
      found = 0; best = 0;
      for (int i = 0; i < SLOTS; i++)
         if (used[i] && (phases[i] == rms_pkg::PH_READY || phases[i] == rms_pkg::PH_RUN))
            if (!found || periods[i] < periods[best]) begin
               found = 1; best = i;
            end
      for (int i = 0; i < SLOTS; i++)
         if (used[i] && phases[i] == rms_pkg::PH_RUN) phases[i] = rms_pkg::PH_READY;
      if (found) begin
         phases[best] = rms_pkg::PH_RUN; cur_slot = best; cur_flag = 1;
      end else begin
         cur_slot = 0; cur_flag = 0;
      end
   endfunction

   function rms_pkg::status_type admit(logic [21:0] id, logic [15:0] p, logic [15:0] c);
      int f;
      int unsigned u;
      if (p == 0) return rms_pkg::ST_NO_SLOT;
      f = -1;
      for (int i = 0; i < SLOTS; i++) if (!used[i] && f < 0) f = i;
      if (f < 0) return rms_pkg::ST_NO_SLOT;
      u = (int'(c) * 1000) / int'(p);
      if (util_sum + u > 693) return rms_pkg::ST_REFUSED;
      used[f] = 1; ids[f] = id; periods[f] = p; utils[f] = u[9:0];
      phases[f] = rms_pkg::PH_SLEEP;
      util_sum += u[9:0];
      return rms_pkg::ST_DONE;
   endfunction

   function rms_pkg::status_type remove(logic [21:0] id);
      bit hit;
      hit = 0;
      for (int i = 0; i < SLOTS; i++)
         if (used[i] && ids[i] == id) begin
            hit = 1;
            if (cur_flag && cur_slot == i) begin
               cur_flag = 0; cur_slot = 0;
            end
            util_sum -= utils[i];
            used[i] = 0;
         end
      return hit ? rms_pkg::ST_DONE : rms_pkg::ST_NOT_FOUND;
   endfunction

   function rms_pkg::status_type set_phase(logic [21:0] id, logic [1:0] ph);
      bit hit;
      hit = 0;
      for (int i = 0; i < SLOTS; i++)
         if (used[i] && ids[i] == id) begin
            hit = 1; phases[i] = ph;
         end
      reschedule();
      return hit ? rms_pkg::ST_DONE : rms_pkg::ST_NOT_FOUND;
   endfunction

   // note one accepted command
   function void note_command(rms_pkg::op_type op, logic [21:0] id, logic [15:0] p,
                              logic [15:0] c);
      rsp_type r;
      case (op)
         rms_pkg::OP_REGISTER:   r.status = admit(id, p, c);
         rms_pkg::OP_YIELD:      r.status = set_phase(id, rms_pkg::PH_SLEEP);
         rms_pkg::OP_DEREGISTER: r.status = remove(id);
         default:                r.status = set_phase(id, rms_pkg::PH_READY);
      endcase
      r.run_valid = cur_flag;
      r.run_id = cur_flag ? ids[cur_slot] : '0;
      r.util = util_sum;
      pending.push_back(r);
   endfunction

   // compare one response with the oldest expectation
   function void check_response(logic [1:0] st, logic rv, logic [21:0] rid, logic [9:0] u);
      rsp_type e;
      if (pending.size() == 0) begin
         $error("unexpected response");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
         $error("status expected %0d actual %0d", e.status, st); errors++;
      end
      if (rv !== e.run_valid) begin
         $error("running_valid expected %0d actual %0d", e.run_valid, rv); errors++;
      end
      if (rid !== e.run_id) begin
         $error("running_id expected %0d actual %0d", e.run_id, rid); errors++;
      end
      if (u !== e.util) begin
         $error("total_utilization expected %0d actual %0d", e.util, u); errors++;
      end
   endfunction
endclass

module tb_rate_monotonic_task_scheduler;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [21:0] req_task_id;
   logic [15:0] req_period_ms;
   logic [15:0] req_compute_ms;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_running_valid;
   logic [21:0] rsp_running_id;
   logic [9:0]  rsp_total_utilization;

   sched_scoreboard board;
   logic [21:0] id_pool [8];

   rate_monotonic_task_scheduler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_task_id(req_task_id),
      .req_period_ms(req_period_ms), .req_compute_ms(req_compute_ms),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_running_valid(rsp_running_valid), .rsp_running_id(rsp_running_id),
      .rsp_total_utilization(rsp_total_utilization)
   );

   // clock generation
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_response(rsp_status, rsp_running_valid, rsp_running_id,
                              rsp_total_utilization);
   end

   // one command transfer, preceded by a random gap; start stays high on no gap
   task automatic send_command(rms_pkg::op_type op, logic [21:0] id, logic [15:0] p,
                               logic [15:0] c);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_operation <= op;
      req_task_id <= id;
      req_period_ms <= p;
      req_compute_ms <= c;
      do @(posedge clock); while (busy);
      board.note_command(op, id, p, c);
   endtask

   // drop start and wait for every expected response
   task automatic wait_drained();
      start <= 0;
      do @(posedge clock); while (board.pending.size() != 0);
   endtask

   // random command leaning toward well-formed task lifecycles
   task automatic random_command();
      int sel;
      logic [21:0] id;
      logic [15:0] p, c;
      sel = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) == 0) ? 22'($urandom) : id_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 15) == 0) p = 16'($urandom);
      else p = 16'($urandom_range(1, 200));
      if ($urandom_range(0, 15) == 0) c = 16'($urandom);
      else c = 16'($urandom_range(0, p / 8 + 1));
      if ($urandom_range(0, 40) == 0) p = 0;
      if (sel < 30)
         send_command(rms_pkg::OP_REGISTER, id, p, c);
      else if (sel < 65)
         send_command(rms_pkg::OP_WAKE, id, p, c);
      else if (sel < 88)
         send_command(rms_pkg::OP_YIELD, id, p, c);
      else
         send_command(rms_pkg::OP_DEREGISTER, id, p, c);
   endtask

   // stimulus
   initial begin
      board = new();
      board.clear();
      reset <= 1;
      start <= 0;
      req_operation <= rms_pkg::OP_REGISTER;
      req_task_id <= '0;
      req_period_ms <= '0;
      req_compute_ms <= '0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero period, refusal, extremes, unknown id, duplicates, full table
      send_command(rms_pkg::OP_REGISTER, 22'd5, 16'd0, 16'hFFFF);
      send_command(rms_pkg::OP_REGISTER, 22'h3FFFFF, 16'hFFFF, 16'hFFFF);
      send_command(rms_pkg::OP_REGISTER, 22'd1, 16'd1, 16'd1);
      send_command(rms_pkg::OP_WAKE, 22'd9, 16'd0, 16'd0);
      send_command(rms_pkg::OP_REGISTER, 22'h3FFFFF, 16'hFFFF, 16'd0);
      send_command(rms_pkg::OP_REGISTER, 22'd0, 16'd10, 16'd3);
      send_command(rms_pkg::OP_REGISTER, 22'd0, 16'd10, 16'd3);
      send_command(rms_pkg::OP_WAKE, 22'd0, 16'd0, 16'd0);
      send_command(rms_pkg::OP_WAKE, 22'h3FFFFF, 16'd0, 16'd0);
      send_command(rms_pkg::OP_YIELD, 22'd0, 16'd0, 16'd0);
      send_command(rms_pkg::OP_WAKE, 22'd0, 16'd0, 16'd0);
      send_command(rms_pkg::OP_DEREGISTER, 22'd0, 16'd0, 16'd0);
      send_command(rms_pkg::OP_YIELD, 22'h2AAAAA, 16'd0, 16'd0);
      send_command(rms_pkg::OP_DEREGISTER, 22'h155555, 16'd0, 16'd0);
      for (int i = 0; i < 17; i++)
         send_command(rms_pkg::OP_REGISTER, 22'(100 + i), 16'hFFFF, 16'd1);
      send_command(rms_pkg::OP_WAKE, 22'd110, 16'd0, 16'd0);
      wait_drained();
      for (int i = 0; i < 17; i++)
         send_command(rms_pkg::OP_DEREGISTER, 22'(100 + i), 16'd0, 16'd0);
      send_command(rms_pkg::OP_DEREGISTER, 22'h3FFFFF, 16'd0, 16'd0);

      // random part, with a fresh id pool every so often
      for (int n = 0; n < 1620; n++) begin
         if (n % 200 == 0)
            for (int k = 0; k < 8; k++) id_pool[k] = 22'($urandom);
         if (n == 800) wait_drained();
         random_command();
      end

      wait_drained();
      repeat (60) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_rate_monotonic_task_scheduler: clean");
      else
         $display("tb_rate_monotonic_task_scheduler: errors");
      $finish;
   end

   // watchdog
   initial begin
      #10000000;
      $display("tb_rate_monotonic_task_scheduler: errors");
      $finish;
   end
endmodule
